@@ hw/rtl/ppm_dual_input_channel_mixer_defines.svh @@
// assertion macros shared by the checker
`ifndef PPM_DUAL_INPUT_CHANNEL_MIXER_DEFINES_SVH
`define PPM_DUAL_INPUT_CHANNEL_MIXER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PPMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppmm assertion failed");

// next-cycle implication, disabled during reset
`define PPMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppmm assertion failed");

`endif

@@ hw/rtl/ppmm_pkg.sv @@
`default_nettype none

package ppmm_pkg;

    localparam int CHANNELS_DEF     = 8;
    localparam int VALIDITY_MAX_DEF = 3;
    localparam int CENTER_VALUE_DEF = 3000;

    localparam int MAP_SLOTS   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] UNUSED_ENTRY = 4'hF;
    localparam logic [3:0] FRAME_SAT    = 4'hF;
    localparam logic [4:0] INDEX_SAT    = 5'd31;
    localparam logic [7:0] MASK_ALL     = 8'hFF;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_GAP          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_PRIMARY   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_SECONDARY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MAP        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MIN_LOW      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MIN_HIGH     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MAX_LOW      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MAX_HIGH     = 3'd7;

    typedef enum logic [1:0] {
        OP_PRIMARY   = 2'd0,
        OP_SECONDARY = 2'd1,
        OP_TICK      = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2
    } t_event;

    typedef struct packed {
        logic        written;
        logic [2:0]  channel;
        logic [15:0] raw;
        t_event      frame_event;
        logic        primary_ok;
        logic        secondary_ok;
        logic [7:0]  restore;
    } t_job;

    typedef struct packed {
        logic        written;
        logic [2:0]  channel;
        logic [15:0] raw;
        logic [15:0] clamped;
        t_event      frame_event;
        logic        primary_ok;
        logic        secondary_ok;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [15:0] frame_gap;
        logic [3:0]  expected_primary;
        logic [3:0]  expected_secondary;
        logic [31:0] channel_map;
    } t_front_cfg;

    typedef struct packed {
        logic [63:0] min_low;
        logic [63:0] min_high;
        logic [63:0] max_low;
        logic [63:0] max_high;
    } t_clamp_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/ppmm_front.sv @@
`default_nettype none

module ppmm_front #(
    parameter int CHANNELS     = ppmm_pkg::CHANNELS_DEF,
    parameter int VALIDITY_MAX = ppmm_pkg::VALIDITY_MAX_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ppmm_pkg::t_front_cfg i_cfg,
    input  wire                  i_valid,
    input  wire  [1:0]           i_operation,
    input  wire  [15:0]          i_high_time,
    input  wire  [15:0]          i_full_time,
    input  wire                  i_full,
    output logic                 o_push,
    output ppmm_pkg::t_job       o_job
);

    localparam logic [2:0] VMAX    = 3'(VALIDITY_MAX);
    localparam logic [4:0] CH_LIM  = 5'(CHANNELS);
    localparam logic [7:0] CH_MASK = 8'((1 << CHANNELS) - 1);

    logic [4:0] r_p_idx, n_p_idx, r_s_idx, n_s_idx;
    logic       r_p_al, n_p_al, r_s_al, n_s_al;
    logic [3:0] r_p_fr, n_p_fr, r_s_fr, n_s_fr;
    logic [2:0] r_p_val, n_p_val, r_s_val, n_s_val;
    logic       r_p_ok, n_p_ok, r_s_ok, n_s_ok;
    logic [7:0] r_ovr, n_ovr;

    logic       is_prim;
    logic [4:0] cur_idx, idx_n;
    logic       cur_al, al_n;
    logic [3:0] cur_fr, fr_n;
    logic [3:0] cur_exp;
    logic [3:0] map_tgt;
    logic [4:0] tgt;
    logic       copy;
    logic [7:0] restore;

    assign o_push = i_valid && !i_full;

    always_comb begin
        n_p_idx = r_p_idx;
        n_s_idx = r_s_idx;
        n_p_al  = r_p_al;
        n_s_al  = r_s_al;
        n_p_fr  = r_p_fr;
        n_s_fr  = r_s_fr;
        n_p_val = r_p_val;
        n_s_val = r_s_val;
        n_p_ok  = r_p_ok;
        n_s_ok  = r_s_ok;
        n_ovr   = r_ovr;

        is_prim = (i_operation == ppmm_pkg::OP_PRIMARY);
        cur_idx = is_prim ? r_p_idx : r_s_idx;
        cur_al  = is_prim ? r_p_al : r_s_al;
        cur_fr  = is_prim ? r_p_fr : r_s_fr;
        cur_exp = is_prim ? i_cfg.expected_primary : i_cfg.expected_secondary;
        idx_n   = cur_idx;
        al_n    = cur_al;
        fr_n    = cur_fr;
        map_tgt = (cur_idx < 5'(ppmm_pkg::MAP_SLOTS))
                ? i_cfg.channel_map[{cur_idx[2:0], 2'b00} +: 4] : ppmm_pkg::UNUSED_ENTRY;
        tgt     = is_prim ? cur_idx : {1'b0, map_tgt};
        copy    = 1'b0;
        restore = '0;

        o_job              = '0;
        o_job.frame_event  = ppmm_pkg::EV_NONE;
        o_job.primary_ok   = r_p_ok;
        o_job.secondary_ok = r_s_ok;

        unique case (i_operation) inside
            ppmm_pkg::OP_PRIMARY, ppmm_pkg::OP_SECONDARY: begin
                if (i_full_time > i_cfg.frame_gap) begin
                    if (cur_idx != {1'b0, cur_exp}) begin
                        al_n              = 1'b0;
                        o_job.frame_event = ppmm_pkg::EV_REJECT;
                    end else begin
                        al_n              = 1'b1;
                        fr_n              = (cur_fr < ppmm_pkg::FRAME_SAT) ? cur_fr + 4'd1 : cur_fr;
                        o_job.frame_event = ppmm_pkg::EV_ACCEPT;
                    end
                    idx_n = '0;
                end else begin
                    if (cur_al) begin
                        if (is_prim) begin
                            copy = (cur_idx >= 5'd8) || !r_ovr[cur_idx[2:0]];
                        end else begin
                            copy = r_s_ok && (map_tgt != ppmm_pkg::UNUSED_ENTRY);
                            if (copy && !map_tgt[3]) begin
                                n_ovr[map_tgt[2:0]] = 1'b1;
                            end
                        end
                        if (copy && tgt < CH_LIM) begin
                            o_job.written = 1'b1;
                            o_job.channel = tgt[2:0];
                            o_job.raw     = i_high_time;
                        end
                    end
                    idx_n = (cur_idx < ppmm_pkg::INDEX_SAT) ? cur_idx + 5'd1 : cur_idx;
                end
                if (is_prim) begin
                    n_p_idx = idx_n;
                    n_p_al  = al_n;
                    n_p_fr  = fr_n;
                end else begin
                    n_s_idx = idx_n;
                    n_s_al  = al_n;
                    n_s_fr  = fr_n;
                end
            end
            ppmm_pkg::OP_TICK: begin
                if (r_p_fr != '0) begin
                    if (r_p_val < VMAX) begin
                        n_p_val = r_p_val + 3'd1;
                        if (n_p_val == VMAX) n_p_ok = 1'b1;
                    end else begin
                        n_p_ok = 1'b1;
                    end
                end else begin
                    n_p_al = 1'b0;
                    if (r_p_val != '0) begin
                        n_p_val = r_p_val - 3'd1;
                        if (n_p_val == '0) n_p_ok = 1'b0;
                    end
                end
                if (r_s_fr != '0) begin
                    if (r_s_val < VMAX) begin
                        n_s_val = r_s_val + 3'd1;
                        if (n_s_val == VMAX) n_s_ok = 1'b1;
                    end else begin
                        n_s_ok = 1'b1;
                    end
                end else begin
                    n_s_al = 1'b0;
                    if (r_s_val != '0) begin
                        n_s_val = r_s_val - 3'd1;
                        if (n_s_val == '0) begin
                            restore = r_ovr & ppmm_pkg::MASK_ALL;
                            n_ovr   = '0;
                            n_s_ok  = 1'b0;
                        end
                    end
                end
                n_p_fr             = '0;
                n_s_fr             = '0;
                o_job.restore      = restore & CH_MASK;
                o_job.primary_ok   = n_p_ok;
                o_job.secondary_ok = n_s_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_idx <= '0;
            r_s_idx <= '0;
            r_p_al  <= 1'b0;
            r_s_al  <= 1'b0;
            r_p_fr  <= '0;
            r_s_fr  <= '0;
            r_p_val <= '0;
            r_s_val <= '0;
            r_p_ok  <= 1'b0;
            r_s_ok  <= 1'b0;
            r_ovr   <= '0;
        end else if (o_push) begin
            r_p_idx <= n_p_idx;
            r_s_idx <= n_s_idx;
            r_p_al  <= n_p_al;
            r_s_al  <= n_s_al;
            r_p_fr  <= n_p_fr;
            r_s_fr  <= n_s_fr;
            r_p_val <= n_p_val;
            r_s_val <= n_s_val;
            r_p_ok  <= n_p_ok;
            r_s_ok  <= n_s_ok;
            r_ovr   <= n_ovr;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ppmm_queue.sv @@
`default_nettype none

module ppmm_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  ppmm_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_head_valid,
    output ppmm_pkg::t_job  o_head,
    input  wire             i_pop
);

    localparam int PW = ppmm_pkg::QUEUE_PTR_W;
    localparam int CW = ppmm_pkg::QUEUE_CNT_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(ppmm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(ppmm_pkg::QUEUE_DEPTH);

    ppmm_pkg::t_job r_mem [ppmm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            if (do_pop)  r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_job;
    end

endmodule

`default_nettype wire

@@ hw/rtl/ppmm_back.sv @@
`default_nettype none

module ppmm_back #(
    parameter int CENTER_VALUE = ppmm_pkg::CENTER_VALUE_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ppmm_pkg::t_clamp_cfg i_clamp,
    input  wire                  i_head_valid,
    input  ppmm_pkg::t_job       i_head,
    output logic                 o_pop,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output ppmm_pkg::t_result    o_result
);

    localparam logic [15:0] CENTER = 16'(CENTER_VALUE);

    logic                r_out_valid;
    ppmm_pkg::t_result   r_out, res;
    logic [7:0]          r_done;
    logic [7:0]          remaining, rest, bit_mask;
    logic [2:0]          low_bit;
    logic                take;
    logic [63:0]         min_word, max_word;
    logic [15:0]         lo, hi;

    always_comb begin
        remaining = i_head.restore & ~r_done;
        low_bit   = '0;
        for (int i = 7; i >= 0; i--) begin
            if (remaining[i]) low_bit = 3'(i);
        end
        bit_mask = 8'b1 << low_bit;
        rest     = remaining & ~bit_mask;
        take     = i_head_valid && (!r_out_valid || !i_out_stall);

        res              = '0;
        res.frame_event  = i_head.frame_event;
        res.primary_ok   = i_head.primary_ok;
        res.secondary_ok = i_head.secondary_ok;
        if (remaining == '0) begin
            res.written = i_head.written;
            res.channel = i_head.channel;
            res.raw     = i_head.raw;
            res.last    = 1'b1;
        end else begin
            res.written     = 1'b1;
            res.channel     = low_bit;
            res.raw         = CENTER;
            res.frame_event = ppmm_pkg::EV_NONE;
            res.last        = (rest == '0);
        end

        min_word = res.channel[2] ? i_clamp.min_high : i_clamp.min_low;
        max_word = res.channel[2] ? i_clamp.max_high : i_clamp.max_low;
        lo       = min_word[{res.channel[1:0], 4'b0000} +: 16];
        hi       = max_word[{res.channel[1:0], 4'b0000} +: 16];
        if (!res.written)      res.clamped = '0;
        else if (res.raw > hi) res.clamped = hi;
        else if (res.raw < lo) res.clamped = lo;
        else                   res.clamped = res.raw;

        o_pop = take && res.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                if (res.last)             r_done <= '0;
                else                      r_done <= r_done | bit_mask;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/ppm_dual_input_channel_mixer.sv @@
// two-stream ppm channel mixer
// input channel: i_in_valid / o_in_stall carry one word (operation, high_time,
//   full_time); a word is taken at a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry result words; o_last marks
//   the final result of an input word
// config: i_cfg_we writes i_cfg_data to i_cfg_index; user must write only while idle, unchecked
// a taken word is queued; its result is then held in the back end output register
// throughput: one input word per cycle while the queue is not full; a pulse gives one result,
//   a tick gives one result per channel returned to center (up to eight, one empty if none),
//   one per cycle unless the receiver stalls, set by the single output register of the back end
// a four-word queue sits between the decode front end and the result back
//   end; o_in_stall rises only when that queue is full
// receiver stall: the output word holds; the queue fills, then input stalls
// reset (synchronous, active low): all decode state clears, registers take
//   their reset values, the queue empties and no result is shown
`default_nettype none

module ppm_dual_input_channel_mixer #(
    parameter int CHANNELS     = ppmm_pkg::CHANNELS_DEF,
    parameter int VALIDITY_MAX = ppmm_pkg::VALIDITY_MAX_DEF,
    parameter int CENTER_VALUE = ppmm_pkg::CENTER_VALUE_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [ppmm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire  [63:0]                        i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  [1:0]                         i_operation,
    input  wire  [15:0]                        i_high_time,
    input  wire  [15:0]                        i_full_time,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_written,
    output logic [2:0]                         o_channel,
    output logic [15:0]                        o_raw_value,
    output logic [15:0]                        o_clamped_value,
    output logic [1:0]                         o_frame_event,
    output logic                               o_primary_valid,
    output logic                               o_secondary_valid,
    output logic                               o_last
);

    ppmm_pkg::t_front_cfg r_fcfg;
    ppmm_pkg::t_clamp_cfg r_ccfg;

    logic              push, full, head_valid, pop;
    ppmm_pkg::t_job    job, head;
    ppmm_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcfg.frame_gap          <= 16'd6000;
            r_fcfg.expected_primary   <= 4'd8;
            r_fcfg.expected_secondary <= 4'd8;
            r_fcfg.channel_map        <= '1;
            r_ccfg.min_low            <= '0;
            r_ccfg.min_high           <= '0;
            r_ccfg.max_low            <= '1;
            r_ccfg.max_high           <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppmm_pkg::REG_FRAME_GAP:          r_fcfg.frame_gap <= i_cfg_data[15:0];
                ppmm_pkg::REG_EXPECTED_PRIMARY:   r_fcfg.expected_primary <= i_cfg_data[3:0];
                ppmm_pkg::REG_EXPECTED_SECONDARY: r_fcfg.expected_secondary <= i_cfg_data[3:0];
                ppmm_pkg::REG_CHANNEL_MAP:        r_fcfg.channel_map <= i_cfg_data[31:0];
                ppmm_pkg::REG_CLAMP_MIN_LOW:      r_ccfg.min_low <= i_cfg_data;
                ppmm_pkg::REG_CLAMP_MIN_HIGH:     r_ccfg.min_high <= i_cfg_data;
                ppmm_pkg::REG_CLAMP_MAX_LOW:      r_ccfg.max_low <= i_cfg_data;
                ppmm_pkg::REG_CLAMP_MAX_HIGH:     r_ccfg.max_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ppmm_front #(
        .CHANNELS     (CHANNELS),
        .VALIDITY_MAX (VALIDITY_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_fcfg),
        .i_valid     (i_in_valid),
        .i_operation (i_operation),
        .i_high_time (i_high_time),
        .i_full_time (i_full_time),
        .i_full      (full),
        .o_push      (push),
        .o_job       (job)
    );

    ppmm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    ppmm_back #(
        .CENTER_VALUE (CENTER_VALUE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clamp      (r_ccfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_result     (result)
    );

    assign o_in_stall        = full;
    assign o_written         = result.written;
    assign o_channel         = result.channel;
    assign o_raw_value       = result.raw;
    assign o_clamped_value   = result.clamped;
    assign o_frame_event     = result.frame_event;
    assign o_primary_valid   = result.primary_ok;
    assign o_secondary_valid = result.secondary_ok;
    assign o_last            = result.last;

endmodule

`default_nettype wire

@@ hw/rtl/ppmm_checker.sv @@
`default_nettype none
`include "ppm_dual_input_channel_mixer_defines.svh"

module ppmm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_stall,
    input wire        i_written,
    input wire [2:0]  i_channel,
    input wire [15:0] i_raw_value,
    input wire [15:0] i_clamped_value,
    input wire [1:0]  i_frame_event,
    input wire        i_last
);

    // a held word keeps its payload
    `PPMM_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_raw_value) && $stable(i_channel) && $stable(i_last))

    // no write means empty channel fields
    `PPMM_ASSERT_IMP(a_idle_fields, i_clk, i_rst_n, i_out_valid && !i_written, i_channel == 3'd0 && i_raw_value == 16'd0 && i_clamped_value == 16'd0)

    // frame end words are single, non-writing results
    `PPMM_ASSERT_IMP(a_frame_single, i_clk, i_rst_n, i_out_valid && i_frame_event != ppmm_pkg::EV_NONE, i_last && !i_written)

    // only center restores come in runs
    `PPMM_ASSERT_IMP(a_run_writes, i_clk, i_rst_n, i_out_valid && !i_last, i_written && i_frame_event == ppmm_pkg::EV_NONE)

endmodule

bind ppm_dual_input_channel_mixer ppmm_checker u_ppmm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .i_written       (o_written),
    .i_channel       (o_channel),
    .i_raw_value     (o_raw_value),
    .i_clamped_value (o_clamped_value),
    .i_frame_event   (o_frame_event),
    .i_last          (o_last)
);

`default_nettype wire

@@ verif/ppm_dual_input_channel_mixer_checker.sv @@
`timescale 1ns / 100ps

module ppm_dual_input_channel_mixer_checker #(
    parameter int CHANNELS     = ppmm_pkg::CHANNELS_DEF,
    parameter int VALIDITY_MAX = ppmm_pkg::VALIDITY_MAX_DEF,
    parameter int CENTER_VALUE = ppmm_pkg::CENTER_VALUE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [ppmm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire [63:0]                       i_cfg_data,
    input  wire                              i_in_valid,
    input  wire                              i_in_stall,
    input  wire [1:0]                        i_operation,
    input  wire [15:0]                       i_high_time,
    input  wire [15:0]                       i_full_time,
    input  wire                              i_out_valid,
    input  wire                              i_out_stall,
    input  wire                              i_written,
    input  wire [2:0]                        i_channel,
    input  wire [15:0]                       i_raw_value,
    input  wire [15:0]                       i_clamped_value,
    input  wire [1:0]                        i_frame_event,
    input  wire                              i_primary_valid,
    input  wire                              i_secondary_valid,
    input  wire                              i_last,
    output int                               o_mismatches,
    output int                               o_pending
);

    localparam logic [15:0] CENTER_WORD = 16'(CENTER_VALUE);

    ppmm_pkg::t_front_cfg  decode_cfg;
    ppmm_pkg::t_clamp_cfg  clamp_limits;

    logic [4:0]  primary_index;
    logic [4:0]  secondary_index;
    logic        primary_aligned;
    logic        secondary_aligned;
    logic [3:0]  primary_frames;
    logic [3:0]  secondary_frames;
    logic [2:0]  primary_validity;
    logic [2:0]  secondary_validity;
    logic        primary_ok;
    logic        secondary_ok;
    logic [7:0]  override_mask;

    ppmm_pkg::t_result     expected_results[$];

    task automatic reset_predictor();
        decode_cfg.frame_gap          = 16'd6000;
        decode_cfg.expected_primary   = 4'd8;
        decode_cfg.expected_secondary = 4'd8;
        decode_cfg.channel_map        = 32'hFFFF_FFFF;
        clamp_limits.min_low          = '0;
        clamp_limits.min_high         = '0;
        clamp_limits.max_low          = '1;
        clamp_limits.max_high         = '1;
        primary_index      = '0;
        secondary_index    = '0;
        primary_aligned    = 1'b0;
        secondary_aligned  = 1'b0;
        primary_frames     = '0;
        secondary_frames   = '0;
        primary_validity   = '0;
        secondary_validity = '0;
        primary_ok         = 1'b0;
        secondary_ok       = 1'b0;
        override_mask      = '0;
        expected_results.delete();
    endtask

    task automatic write_register(input logic [ppmm_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [63:0] value);
        case (index)
            ppmm_pkg::REG_FRAME_GAP:          decode_cfg.frame_gap = value[15:0];
            ppmm_pkg::REG_EXPECTED_PRIMARY:   decode_cfg.expected_primary = value[3:0];
            ppmm_pkg::REG_EXPECTED_SECONDARY: decode_cfg.expected_secondary = value[3:0];
            ppmm_pkg::REG_CHANNEL_MAP:        decode_cfg.channel_map = value[31:0];
            ppmm_pkg::REG_CLAMP_MIN_LOW:      clamp_limits.min_low = value;
            ppmm_pkg::REG_CLAMP_MIN_HIGH:     clamp_limits.min_high = value;
            ppmm_pkg::REG_CLAMP_MAX_LOW:      clamp_limits.max_low = value;
            ppmm_pkg::REG_CLAMP_MAX_HIGH:     clamp_limits.max_high = value;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] clamp_value(input logic [2:0] channel,
                                                input logic [15:0] value);
        logic [63:0] min_word;
        logic [63:0] max_word;
        min_word = channel[2] ? clamp_limits.min_high : clamp_limits.min_low;
        max_word = channel[2] ? clamp_limits.max_high : clamp_limits.max_low;
        min_word = min_word >> {channel[1:0], 4'b0000};
        max_word = max_word >> {channel[1:0], 4'b0000};
        if (value > max_word[15:0])
            return max_word[15:0];
        if (value < min_word[15:0])
            return min_word[15:0];
        return value;
    endfunction

    function automatic ppmm_pkg::t_result make_result(input logic written,
                                                      input logic [2:0] channel,
                                                      input logic [15:0] raw,
                                                      input ppmm_pkg::t_event frame_event);
        ppmm_pkg::t_result word;
        word.written      = written;
        word.channel      = channel;
        word.raw          = raw;
        word.clamped      = written ? clamp_value(channel, raw) : 16'd0;
        word.frame_event  = frame_event;
        word.primary_ok   = primary_ok;
        word.secondary_ok = secondary_ok;
        word.last         = 1'b0;
        return word;
    endfunction

    task automatic predict_word(input logic [1:0] op, input logic [15:0] high_time,
                                input logic [15:0] full_time);
        logic              is_primary;
        logic [4:0]        idx;
        logic              aligned;
        logic [3:0]        frames;
        logic [3:0]        want;
        logic [31:0]       map_shifted;
        logic [3:0]        target;
        logic [7:0]        restore;
        logic [3:0]        ch;
        ppmm_pkg::t_result word;
        ppmm_pkg::t_result batch[$];
        word = make_result(1'b0, 3'd0, 16'd0, ppmm_pkg::EV_NONE);
        case (op)
            ppmm_pkg::OP_PRIMARY, ppmm_pkg::OP_SECONDARY: begin
                is_primary = (op == ppmm_pkg::OP_PRIMARY);
                idx     = is_primary ? primary_index : secondary_index;
                aligned = is_primary ? primary_aligned : secondary_aligned;
                frames  = is_primary ? primary_frames : secondary_frames;
                want    = is_primary ? decode_cfg.expected_primary
                                     : decode_cfg.expected_secondary;
                if (full_time > decode_cfg.frame_gap) begin
                    if (idx != {1'b0, want}) begin
                        aligned = 1'b0;
                        word.frame_event = ppmm_pkg::EV_REJECT;
                    end else begin
                        aligned = 1'b1;
                        if (frames != ppmm_pkg::FRAME_SAT)
                            frames++;
                        word.frame_event = ppmm_pkg::EV_ACCEPT;
                    end
                    idx = '0;
                end else begin
                    if (aligned) begin
                        if (is_primary) begin
                            // overridden channels are left to the secondary stream
                            if (idx < CHANNELS && !override_mask[idx[2:0]])
                                word = make_result(1'b1, idx[2:0], high_time,
                                                   ppmm_pkg::EV_NONE);
                        end else begin
                            map_shifted = decode_cfg.channel_map >> {idx[2:0], 2'b00};
                            target = (idx < ppmm_pkg::MAP_SLOTS) ? map_shifted[3:0]
                                                                 : ppmm_pkg::UNUSED_ENTRY;
                            if (secondary_ok && target != ppmm_pkg::UNUSED_ENTRY) begin
                                if (target < 8)
                                    override_mask[target[2:0]] = 1'b1;
                                if (target < CHANNELS)
                                    word = make_result(1'b1, target[2:0], high_time,
                                                       ppmm_pkg::EV_NONE);
                            end
                        end
                    end
                    if (idx != ppmm_pkg::INDEX_SAT)
                        idx++;
                end
                if (is_primary) begin
                    primary_index   = idx;
                    primary_aligned = aligned;
                    primary_frames  = frames;
                end else begin
                    secondary_index   = idx;
                    secondary_aligned = aligned;
                    secondary_frames  = frames;
                end
                word.last = 1'b1;
                expected_results.push_back(word);
            end
            ppmm_pkg::OP_TICK: begin
                restore = '0;
                if (primary_frames != 0) begin
                    if (primary_validity < VALIDITY_MAX) begin
                        primary_validity++;
                        if (primary_validity == VALIDITY_MAX)
                            primary_ok = 1'b1;
                    end else begin
                        primary_ok = 1'b1;
                    end
                end else begin
                    primary_aligned = 1'b0;
                    if (primary_validity != 0) begin
                        primary_validity--;
                        if (primary_validity == 0)
                            primary_ok = 1'b0;
                    end
                end
                if (secondary_frames != 0) begin
                    if (secondary_validity < VALIDITY_MAX) begin
                        secondary_validity++;
                        if (secondary_validity == VALIDITY_MAX)
                            secondary_ok = 1'b1;
                    end else begin
                        secondary_ok = 1'b1;
                    end
                end else begin
                    secondary_aligned = 1'b0;
                    if (secondary_validity != 0) begin
                        secondary_validity--;
                        // secondary lost: overridden channels go back to center
                        if (secondary_validity == 0) begin
                            restore       = override_mask;
                            override_mask = '0;
                            secondary_ok  = 1'b0;
                        end
                    end
                end
                primary_frames   = '0;
                secondary_frames = '0;
                for (ch = 0; ch < 8; ch++) begin
                    if (restore[ch[2:0]] && ch < CHANNELS)
                        batch.push_back(make_result(1'b1, ch[2:0], CENTER_WORD,
                                                    ppmm_pkg::EV_NONE));
                end
                if (batch.size() == 0)
                    batch.push_back(make_result(1'b0, 3'd0, 16'd0, ppmm_pkg::EV_NONE));
                word = batch.pop_back();
                word.last = 1'b1;
                batch.push_back(word);
                foreach (batch[k])
                    expected_results.push_back(batch[k]);
            end
            default: begin
                word.last = 1'b1;
                expected_results.push_back(word);
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        o_mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_word();
        ppmm_pkg::t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected, channel %0d raw %0h",
                                      i_channel, i_raw_value));
            return;
        end
        want = expected_results.pop_front();
        compare_field("written", i_written, want.written);
        compare_field("channel", i_channel, want.channel);
        compare_field("raw_value", i_raw_value, want.raw);
        compare_field("clamped_value", i_clamped_value, want.clamped);
        compare_field("frame_event", i_frame_event, want.frame_event);
        compare_field("primary_valid", i_primary_valid, want.primary_ok);
        compare_field("secondary_valid", i_secondary_valid, want.secondary_ok);
        compare_field("last", i_last, want.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_predictor();
        end else begin
            if (i_cfg_we)
                write_register(i_cfg_index, i_cfg_data);
            // results never come out in the cycle their input word is taken
            if (i_out_valid && !i_out_stall)
                check_word();
            if (i_in_valid && !i_in_stall)
                predict_word(i_operation, i_high_time, i_full_time);
        end
        o_pending = expected_results.size();
    end

endmodule

@@ verif/ppm_dual_input_channel_mixer_tb.sv @@
`timescale 1ns / 100ps

module ppm_dual_input_channel_mixer_tb;

    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_operation = '0;
    logic [15:0] i_high_time = '0;
    logic [15:0] i_full_time = '0;
    logic        i_out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_written;
    logic [2:0]  o_channel;
    logic [15:0] o_raw_value;
    logic [15:0] o_clamped_value;
    logic [1:0]  o_frame_event;
    logic        o_primary_valid;
    logic        o_secondary_valid;
    logic        o_last;

    int          mismatches;
    int          pending;

    logic [63:0] settings[8];
    logic [15:0] gap_now;
    logic [3:0]  want_primary;
    logic [3:0]  want_secondary;
    logic        quiet = 1'b0;
    int          words_sent = 0;
    int          phase_budget[6] = '{45, 25, 20, 40, 30, 50};

    ppm_dual_input_channel_mixer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_high_time       (i_high_time),
        .i_full_time       (i_full_time),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_written         (o_written),
        .o_channel         (o_channel),
        .o_raw_value       (o_raw_value),
        .o_clamped_value   (o_clamped_value),
        .o_frame_event     (o_frame_event),
        .o_primary_valid   (o_primary_valid),
        .o_secondary_valid (o_secondary_valid),
        .o_last            (o_last)
    );

    ppm_dual_input_channel_mixer_checker u_mixer_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_high_time       (i_high_time),
        .i_full_time       (i_full_time),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_written         (o_written),
        .i_channel         (o_channel),
        .i_raw_value       (o_raw_value),
        .i_clamped_value   (o_clamped_value),
        .i_frame_event     (o_frame_event),
        .i_primary_valid   (o_primary_valid),
        .i_secondary_valid (o_secondary_valid),
        .i_last            (o_last),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99, 0) < 11);
    end

    function automatic logic [15:0] any_value();
        return 16'($urandom_range(65535, 0));
    endfunction

    function automatic logic [15:0] pulse_time();
        return 16'($urandom_range(gap_now, 0));
    endfunction

    function automatic logic [15:0] gap_time();
        if (gap_now == 16'hFFFF)
            return 16'hFFFF;
        return 16'($urandom_range(65535, gap_now + 1));
    endfunction

    function automatic logic [31:0] random_map();
        logic [31:0] map;
        int          pick;
        map = '0;
        repeat (ppmm_pkg::MAP_SLOTS) begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
                map = (map << 4) | $urandom_range(7, 0);
            else if (pick < 85)
                map = (map << 4) | 32'(ppmm_pkg::UNUSED_ENTRY);
            else
                map = (map << 4) | $urandom_range(14, 8);
        end
        return map;
    endfunction

    function automatic int frame_count(input logic [3:0] want);
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 85)
            return want;
        if (pick < 93)
            return want + 1;
        return $urandom_range(15, 0);
    endfunction

    task automatic apply_settings();
        logic [3:0] r;
        i_cfg_we <= 1'b1;
        for (r = 0; r <= ppmm_pkg::REG_CLAMP_MAX_HIGH; r++) begin
            i_cfg_index <= r[2:0];
            i_cfg_data  <= settings[r[2:0]];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        gap_now        = settings[ppmm_pkg::REG_FRAME_GAP][15:0];
        want_primary   = settings[ppmm_pkg::REG_EXPECTED_PRIMARY][3:0];
        want_secondary = settings[ppmm_pkg::REG_EXPECTED_SECONDARY][3:0];
    endtask

    task automatic send_word(input logic [1:0] op, input logic [15:0] high_time,
                             input logic [15:0] full_time);
        while (!quiet && $urandom_range(99, 0) < 11) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_high_time <= high_time;
        i_full_time <= full_time;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_frame(input logic [1:0] op, input int count);
        send_word(op, any_value(), gap_time());
        repeat (count)
            send_word(op, any_value(), pulse_time());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (4)
            @(negedge i_clk);
    endtask

    task automatic run_episode();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 60) begin
            if ($urandom_range(3, 0) != 0)
                send_frame(ppmm_pkg::OP_PRIMARY, frame_count(want_primary));
            if ($urandom_range(9, 0) != 0)
                send_frame(ppmm_pkg::OP_SECONDARY, frame_count(want_secondary));
            send_word(ppmm_pkg::OP_TICK, any_value(), any_value());
        end else if (pick < 80) begin
            repeat ($urandom_range(4, 1))
                send_word(ppmm_pkg::OP_TICK, any_value(), any_value());
        end else if (pick < 96) begin
            repeat ($urandom_range(6, 1))
                send_word(2'($urandom_range(3, 0)), any_value(), any_value());
        end else begin
            send_frame(2'($urandom_range(1, 0)), int'($urandom_range(34, 31)));
        end
    endtask

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int phase;
        int phase_end;
        repeat (10)
            @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: ch0 and ch3 carry tight limits, secondary slot 0 -> ch3, slot 1 -> 9
        settings[ppmm_pkg::REG_FRAME_GAP]          = 64'd100;
        settings[ppmm_pkg::REG_EXPECTED_PRIMARY]   = 64'd2;
        settings[ppmm_pkg::REG_EXPECTED_SECONDARY] = 64'd0;
        settings[ppmm_pkg::REG_CHANNEL_MAP]        = 64'hFFFF_FF93;
        settings[ppmm_pkg::REG_CLAMP_MIN_LOW]      = {16'd1000, 16'd0, 16'd0, 16'h0010};
        settings[ppmm_pkg::REG_CLAMP_MIN_HIGH]     = '0;
        settings[ppmm_pkg::REG_CLAMP_MAX_LOW]      = {16'd2000, 16'hFFFF, 16'hFFFF, 16'hFFF0};
        settings[ppmm_pkg::REG_CLAMP_MAX_HIGH]     = '1;
        apply_settings();
        send_word(OP_UNDEFINED, 16'hFFFF, 16'hFFFF);
        send_word(ppmm_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_word(ppmm_pkg::OP_PRIMARY, 16'h1234, 16'd101);
        send_word(ppmm_pkg::OP_PRIMARY, 16'h0000, 16'h0000);
        send_word(ppmm_pkg::OP_PRIMARY, 16'hFFFF, 16'd100);
        send_word(ppmm_pkg::OP_PRIMARY, 16'h0000, 16'hFFFF);
        send_word(ppmm_pkg::OP_PRIMARY, 16'hFFFF, 16'd50);
        send_word(ppmm_pkg::OP_PRIMARY, 16'h0000, 16'd50);
        send_word(ppmm_pkg::OP_SECONDARY, 16'h5555, 16'hFFFF);
        send_word(ppmm_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        send_word(ppmm_pkg::OP_SECONDARY, 16'hAAAA, 16'd200);
        send_word(ppmm_pkg::OP_PRIMARY, 16'h0100, 16'd300);
        send_word(ppmm_pkg::OP_TICK, 16'h0000, 16'hFFFF);
        send_word(ppmm_pkg::OP_SECONDARY, 16'h0000, 16'd101);
        send_word(ppmm_pkg::OP_TICK, 16'hFFFF, 16'h0000);
        send_word(ppmm_pkg::OP_SECONDARY, 16'd500, 16'd10);
        send_word(ppmm_pkg::OP_SECONDARY, 16'd3000, 16'd10);
        send_word(ppmm_pkg::OP_SECONDARY, 16'd0, 16'd1000);
        send_word(ppmm_pkg::OP_SECONDARY, 16'd0, 16'd1000);
        send_word(ppmm_pkg::OP_SECONDARY, 16'd2500, 16'd0);
        send_word(ppmm_pkg::OP_PRIMARY, 16'd1234, 16'd7);
        send_word(ppmm_pkg::OP_TICK, 16'd0, 16'd0);
        send_word(ppmm_pkg::OP_TICK, 16'd0, 16'd0);
        send_word(ppmm_pkg::OP_TICK, 16'd0, 16'd0);
        send_word(ppmm_pkg::OP_TICK, 16'd0, 16'd0);
        drain();

        for (phase = 0; phase < 6; phase++) begin
            settings[ppmm_pkg::REG_FRAME_GAP]          = 64'($urandom_range(60000, 1000));
            settings[ppmm_pkg::REG_EXPECTED_PRIMARY]   = 64'($urandom_range(4, 1));
            settings[ppmm_pkg::REG_EXPECTED_SECONDARY] = 64'($urandom_range(4, 1));
            settings[ppmm_pkg::REG_CHANNEL_MAP]        = 64'(random_map());
            settings[ppmm_pkg::REG_CLAMP_MIN_LOW]      = {$urandom, $urandom};
            settings[ppmm_pkg::REG_CLAMP_MIN_HIGH]     = {$urandom, $urandom};
            settings[ppmm_pkg::REG_CLAMP_MAX_LOW]      = {$urandom, $urandom};
            settings[ppmm_pkg::REG_CLAMP_MAX_HIGH]     = {$urandom, $urandom};
            case (phase)
                1: begin
                    settings[ppmm_pkg::REG_FRAME_GAP]          = '0;
                    settings[ppmm_pkg::REG_EXPECTED_PRIMARY]   = '0;
                    settings[ppmm_pkg::REG_EXPECTED_SECONDARY] = 64'd3;
                    settings[ppmm_pkg::REG_CHANNEL_MAP]        = 64'hFFFF_FFFF;
                    settings[ppmm_pkg::REG_CLAMP_MIN_LOW]      = '0;
                    settings[ppmm_pkg::REG_CLAMP_MIN_HIGH]     = '0;
                    settings[ppmm_pkg::REG_CLAMP_MAX_LOW]      = '1;
                    settings[ppmm_pkg::REG_CLAMP_MAX_HIGH]     = '1;
                end
                2: begin
                    settings[ppmm_pkg::REG_FRAME_GAP]          = 64'hFFFF;
                    settings[ppmm_pkg::REG_EXPECTED_PRIMARY]   = 64'd15;
                    settings[ppmm_pkg::REG_EXPECTED_SECONDARY] = 64'd15;
                    settings[ppmm_pkg::REG_CHANNEL_MAP]        = '0;
                    settings[ppmm_pkg::REG_CLAMP_MIN_LOW]      = '1;
                    settings[ppmm_pkg::REG_CLAMP_MIN_HIGH]     = '1;
                    settings[ppmm_pkg::REG_CLAMP_MAX_LOW]      = '0;
                    settings[ppmm_pkg::REG_CLAMP_MAX_HIGH]     = '0;
                end
                3: settings[ppmm_pkg::REG_EXPECTED_PRIMARY] = 64'd15;
                default: ;
            endcase
            apply_settings();
            quiet = (phase == 3);
            // index saturation on both streams
            if (phase == 4) begin
                send_frame(ppmm_pkg::OP_PRIMARY, 33);
                send_frame(ppmm_pkg::OP_SECONDARY, 33);
            end
            phase_end = words_sent + phase_budget[phase];
            while (words_sent < phase_end)
                run_episode();
            drain();
        end
        quiet = 1'b0;

        repeat (10)
            @(negedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
